>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and helpers for the pressure/temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

	typedef struct packed {
		logic        cmd;
		logic [19:0] adc_raw;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] temp_centi;
		logic [31:0] pressure_pa;
		logic        div_zero;
	} out_item_t;

	localparam logic [1:0] REG_TEMP_CAL = 2'd0;
	localparam logic [1:0] REG_PRES_A   = 2'd1;
	localparam logic [1:0] REG_PRES_B   = 2'd2;
	localparam logic [1:0] REG_PRES_C   = 2'd3;

	localparam logic CMD_TEMP = 1'b0;
	localparam logic CMD_PRES = 1'b1;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		OP_LOAD,
		OP_T_A, OP_T_B, OP_T_C, OP_T_D, OP_T_E,
		OP_P_A, OP_P_B, OP_P_C, OP_P_D, OP_P_E, OP_P_F, OP_P_G, OP_P_H,
		OP_P_I, OP_P_J, OP_P_K, OP_P_L, OP_P_M, OP_P_N, OP_P_O,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEMP,
		ST_PRES,
		ST_DIV,
		ST_POST,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic div_start;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic v1_zero;
	} dp_status_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction

endpackage

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Radix-2 restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial    = {rem_q, quo_q[31]} - {1'b0, dsr_q};
	assign busy     = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(start && busy)) else $error("divider restarted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("divider did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'd32) else $error("divider count out of range");
endmodule

>>> rtl/ptc_datapath.sv
// ----------------------------------------------------------------------------
// ptc_datapath
// Calibration registers, fine temperature, one shared multiplier per step.
// ----------------------------------------------------------------------------
module ptc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  ptc_pkg::in_item_t  item,
	input  ptc_pkg::dp_cmd_t   ctl,
	output ptc_pkg::dp_status_t sts,
	output ptc_pkg::out_item_t result
);
	import ptc_pkg::*;

	logic [47:0] tcal_q;
	logic [63:0] pa_q, pb_q;
	logic [15:0] pc_q;
	logic [31:0] fine_q;
	logic        cmd_q, dz_q;
	logic [19:0] adc_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] ma, mb, prod;
	out_item_t   res_q;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] div_q;
	logic        div_busy;
	logic [31:0] dvd;
	logic [31:0] pq;

	assign t1 = {16'd0, tcal_q[15:0]};
	assign t2 = sx16(tcal_q[31:16]);
	assign t3 = sx16(tcal_q[47:32]);
	assign p1 = {16'd0, pa_q[15:0]};
	assign p2 = sx16(pa_q[31:16]);
	assign p3 = sx16(pa_q[47:32]);
	assign p4 = sx16(pa_q[63:48]);
	assign p5 = sx16(pb_q[15:0]);
	assign p6 = sx16(pb_q[31:16]);
	assign p7 = sx16(pb_q[47:32]);
	assign p8 = sx16(pb_q[63:48]);
	assign p9 = sx16(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pa_q   <= '0;
			pb_q   <= '0;
			pc_q   <= '0;
			fine_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TEMP_CAL: tcal_q <= cfg_data[47:0];
					REG_PRES_A:   pa_q   <= cfg_data;
					REG_PRES_B:   pb_q   <= cfg_data;
					REG_PRES_C:   pc_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (ctl.op == OP_T_E) fine_q <= a_q + c_q;
		end
	end

	assign pq = e_q[31] ? {div_q[30:0], 1'b0} : div_q;

	// Multiplier operand selection per step
	always_comb begin
		ma = '0;
		mb = '0;
		case (ctl.op)
			OP_T_A: begin ma = {15'd0, adc_q[19:3]} - {t1[30:0], 1'b0}; mb = t2; end
			OP_T_B: begin ma = {16'd0, adc_q[19:4]} - t1; mb = ma; end
			OP_T_C: begin ma = asr(b_q, 12); mb = t3; end
			OP_T_E: begin ma = a_q + c_q; mb = 32'd5; end
			OP_P_B: begin ma = asr(a_q, 2); mb = ma; end
			OP_P_C: begin ma = asr(b_q, 11); mb = p6; end
			OP_P_D: begin ma = a_q; mb = p5; end
			OP_P_E: begin ma = p3; mb = asr(b_q, 13); end
			OP_P_F: begin ma = p2; mb = a_q; end
			OP_P_G: begin ma = 32'd32768 + asr(asr(d_q, 3) + asr(e_q, 1), 18); mb = p1; end
			OP_P_H: begin ma = (32'd1048576 - {12'd0, adc_q}) - asr(c_q, 12);
				mb = 32'd3125; end
			OP_P_K: begin ma = {3'd0, pq[31:3]}; mb = ma; end
			OP_P_L: begin ma = p9; mb = {13'd0, b_q[31:13]}; end
			OP_P_M: begin ma = {2'd0, pq[31:2]}; mb = p8; end
			default: ;
		endcase
	end

	assign prod = ma * mb;
	assign dvd  = b_q[31] ? b_q : {b_q[30:0], 1'b0};

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dvd),
		.divisor  (d_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin cmd_q <= item.cmd; adc_q <= item.adc_raw; end
			OP_T_A:  a_q <= asr(prod, 11);
			OP_T_B:  b_q <= prod;
			OP_T_C:  c_q <= asr(prod, 14);
			OP_T_E:  d_q <= asr(prod + 32'd128, 8);
			OP_P_A:  a_q <= asr(fine_q, 1) - 32'd64000;
			OP_P_B:  b_q <= prod;
			OP_P_C:  c_q <= prod;
			OP_P_D:  c_q <= asr(c_q + {prod[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
			OP_P_E:  d_q <= prod;
			OP_P_F:  e_q <= prod;
			OP_P_G:  begin d_q <= asr(prod, 15); dz_q <= (asr(prod, 15) == 32'd0); end
			OP_P_H:  begin b_q <= prod; e_q <= {prod[31], 31'd0}; end
			OP_P_K:  b_q <= prod;
			OP_P_L:  b_q <= asr(prod, 12);
			OP_P_M:  a_q <= asr(prod, 13);
			OP_P_N:  a_q <= pq + asr(b_q + a_q + p7, 4);
			OP_P_I:  e_q <= e_q;
			OP_P_J:  begin e_q <= e_q; b_q <= pq; end
			default: ;
		endcase
		if (ctl.op == OP_P_J) begin
			a_q <= pq;
		end
	end

	// Register the result beat
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_q.kind        <= cmd_q;
			res_q.temp_centi  <= (cmd_q == CMD_TEMP) ? d_q : 32'd0;
			res_q.pressure_pa <= (cmd_q == CMD_PRES && !dz_q) ? a_q : 32'd0;
			res_q.div_zero    <= (cmd_q == CMD_PRES) && dz_q;
		end
	end

	assign result       = res_q;
	assign sts.div_busy = div_busy;
	assign sts.v1_zero  = dz_q;
endmodule

>>> rtl/ptc_ctrl.sv
// ----------------------------------------------------------------------------
// ptc_ctrl
// Sequencer: steps the datapath, waits on the divider, drives handshakes.
// ----------------------------------------------------------------------------
module ptc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_stall,
	input  logic                out_stall,
	output logic                out_valid,
	input  ptc_pkg::dp_status_t sts,
	output ptc_pkg::dp_cmd_t    ctl
);
	import ptc_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ov_q    <= ov_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		ov_d          = ov_q && out_stall;
		ctl.op        = OP_NONE;
		ctl.div_start = 1'b0;
		ctl.out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					ctl.op  = OP_LOAD;
					state_d = (in_cmd == CMD_TEMP) ? ST_TEMP : ST_PRES;
					op_d    = (in_cmd == CMD_TEMP) ? OP_T_A : OP_P_A;
				end
			end
			ST_TEMP: begin
				ctl.op = op_q;
				unique case (op_q)
					OP_T_A: op_d = OP_T_B;
					OP_T_B: op_d = OP_T_C;
					OP_T_C: op_d = OP_T_E;
					default: state_d = ST_OUT;
				endcase
			end
			ST_PRES: begin
				ctl.op = op_q;
				unique case (op_q)
					OP_P_A: op_d = OP_P_B;
					OP_P_B: op_d = OP_P_C;
					OP_P_C: op_d = OP_P_D;
					OP_P_D: op_d = OP_P_E;
					OP_P_E: op_d = OP_P_F;
					OP_P_F: op_d = OP_P_G;
					OP_P_G: op_d = OP_P_H;
					default: begin
						state_d = ST_DIV;
						op_d    = OP_P_I;
					end
				endcase
			end
			ST_DIV: begin
				if (sts.v1_zero) begin
					state_d = ST_OUT;
				end else if (op_q == OP_P_I) begin
					ctl.div_start = 1'b1;
					op_d          = OP_NONE;
				end else if (!sts.div_busy) begin
					state_d = ST_POST;
					op_d    = OP_P_J;
				end
			end
			ST_POST: begin
				ctl.op = op_q;
				unique case (op_q)
					OP_P_J: op_d = OP_P_K;
					OP_P_K: op_d = OP_P_L;
					OP_P_L: op_d = OP_P_M;
					OP_P_M: op_d = OP_P_N;
					default: state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				if (!(ov_q && out_stall)) begin
					ctl.out_load = 1'b1;
					ov_d         = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	property p_load_idle;
		@(posedge clk) disable iff (!arst_n) ctl.out_load |-> state_q == ST_OUT;
	endproperty
	assert property (p_load_idle) else $error("result loaded outside output step");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |=> sts.div_busy) else $error("divider did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("stalled result dropped");
endmodule

>>> rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// 32-bit integer temperature and pressure compensation for a barometric sensor.
//
//  channel   direction  handshake         beat
//  in        in         in_valid/stall    ptc_pkg::in_item_t
//  out       out        out_valid/stall   ptc_pkg::out_item_t
//  cfg       in         cfg_valid/ready   index, 64-bit data
//
//  Temperature item: runs the temperature steps, then the output step.
//  Pressure item: runs the pressure steps, the serial divider and the
//  post-divide steps; a zero divisor skips the divide and the post steps.
//  One item at a time; the input stalls until the result is registered,
//  and a result still stalled at the output holds the next one back.
//  Reset clears the calibration registers and fine temperature.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ptc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ptc_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import ptc_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	ptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_data.cmd),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	ptc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.result    (out_data)
	);
endmodule
